// ----- rtl/pss_pkg.sv -----
// Package for the positional sequence store: operation and status codes,
// sequencer states and the structs passed between the store's modules.
// Depends on nothing.
package pss_pkg;

  localparam int unsigned FuncW = 3;
  localparam int unsigned ValW  = 32;
  localparam int unsigned PosW  = 8;

  typedef enum logic [FuncW-1:0] {
    FN_INS_FRONT = 3'd0,
    FN_INS_BACK  = 3'd1,
    FN_INS_AT    = 3'd2,
    FN_DEL_FRONT = 3'd3,
    FN_DEL_BACK  = 3'd4,
    FN_DEL_AT    = 3'd5,
    FN_DUMP      = 3'd6
  } func_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SHIFT,
    S_DRAIN,
    S_PUT,
    S_DUMP,
    S_RESULT
  } state_e;

  // Enables of the entry memory's two ports.
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

  // Width-independent part of one result.
  typedef struct packed {
    status_e              status;
    logic signed [ValW-1:0] item_value;
    logic                 last;
  } res_t;

endpackage

// ----- rtl/pss_mem.sv -----
// Entry memory of the positional sequence store: one write port and one
// read port with registered read data.
// Depends on pss_pkg.
module pss_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                   clk_i,
  input  pss_pkg::mem_ctl_t      ctl_i,
  input  logic [AddrW-1:0]       waddr_i,
  input  logic [pss_pkg::ValW-1:0] wdata_i,
  input  logic [AddrW-1:0]       raddr_i,
  output logic [pss_pkg::ValW-1:0] rdata_o
);
  import pss_pkg::*;

  logic [ValW-1:0] mem_q [Depth];
  logic [ValW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/pss_ctrl.sv -----
// Sequencer of the positional sequence store: decodes and checks a request and
// walks memory one slot per cycle (dumps can stall) with a shared address stepper.
// Depends on pss_pkg.
module pss_ctrl #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = $clog2(Depth),
  parameter int unsigned CntW  = $clog2(Depth + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [pss_pkg::FuncW-1:0] func_i,
  input  logic [pss_pkg::ValW-1:0]  value_i,
  input  logic [pss_pkg::PosW-1:0]  position_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output pss_pkg::res_t            res_o,
  output logic [CntW-1:0]          res_index_o,
  output logic [CntW-1:0]          count_o,
  output pss_pkg::mem_ctl_t        mem_ctl_o,
  output logic [AddrW-1:0]         mem_waddr_o,
  output logic [pss_pkg::ValW-1:0]  mem_wdata_o,
  output logic [AddrW-1:0]         mem_raddr_o,
  input  logic [pss_pkg::ValW-1:0]  mem_rdata_i
);
  import pss_pkg::*;

  localparam int unsigned CmpW = PosW + 1;

  state_e          state_q, state_d;
  logic [FuncW-1:0] op_q, op_d;
  logic [ValW-1:0] val_q, val_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [CntW-1:0] count_q, count_d;
  logic [AddrW-1:0] ptr_q, ptr_d;
  logic [AddrW-1:0] wa_q, wa_d;
  logic [AddrW-1:0] slot_q, slot_d;
  status_e         st_q, st_d;
  logic            ins_q, ins_d;
  logic            pend_q, pend_d;

  // Decode of the held request.
  logic            is_ins, is_del, is_dump;
  logic [CmpW-1:0] pos_x, cnt_x;
  logic            full, empty, ins_bad, del_bad;
  logic [CntW-1:0] slot_c;
  status_e         dec_st;
  logic            need_shift;
  // Shared address stepper: moves the read pointer and forms the write slot.
  logic [AddrW-1:0] ptr_step, ptr_back;
  logic            shift_done;
  logic [CntW-1:0] dump_idx;
  logic            dump_last;

  always_comb begin
    is_ins  = op_q inside {FN_INS_FRONT, FN_INS_BACK, FN_INS_AT};
    is_del  = op_q inside {FN_DEL_FRONT, FN_DEL_BACK, FN_DEL_AT};
    is_dump = (op_q == FN_DUMP);
    pos_x   = CmpW'(pos_q);
    cnt_x   = CmpW'(count_q);
    full    = (count_q == CntW'(Depth));
    empty   = (count_q == '0);
    ins_bad = (op_q == FN_INS_AT) && ((pos_q == '0) || (pos_x > cnt_x + CmpW'(1)));
    del_bad = (op_q == FN_DEL_AT) && ((pos_q == '0) || (pos_x > cnt_x));

    case (op_q)
      FN_INS_FRONT, FN_DEL_FRONT: slot_c = '0;
      FN_INS_BACK:                slot_c = count_q;
      FN_DEL_BACK:                slot_c = count_q - CntW'(1);
      default:                    slot_c = CntW'(pos_q - PosW'(1));
    endcase

    dec_st = ST_OK;
    if (is_ins) begin
      if (ins_bad) begin
        dec_st = ST_BADPOS;
      end else if (full) begin
        dec_st = ST_FULL;
      end
    end else if (is_del) begin
      if (empty) begin
        dec_st = ST_EMPTY;
      end else if (del_bad) begin
        dec_st = ST_BADPOS;
      end
    end else if (is_dump && empty) begin
      dec_st = ST_EMPTY;
    end

    if (is_ins) begin
      need_shift = (slot_c < count_q);
    end else begin
      need_shift = ((slot_c + CntW'(1)) < count_q);
    end

    ptr_step   = ins_q ? (ptr_q - AddrW'(1)) : (ptr_q + AddrW'(1));
    ptr_back   = ins_q ? (ptr_q + AddrW'(1)) : (ptr_q - AddrW'(1));
    shift_done = ins_q ? (ptr_q == slot_q) : (ptr_q == AddrW'(count_q - CntW'(1)));
    dump_idx   = CntW'(ptr_q) + CntW'(1);
    dump_last  = (dump_idx == count_q);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (dec_st != ST_OK) begin
          state_d = S_RESULT;
        end else if (is_ins) begin
          state_d = need_shift ? S_SHIFT : S_PUT;
        end else if (is_del) begin
          state_d = need_shift ? S_SHIFT : S_RESULT;
        end else if (is_dump) begin
          state_d = S_DUMP;
        end else begin
          state_d = S_RESULT;
        end
      end
      S_SHIFT: begin
        if (shift_done) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = ins_q ? S_PUT : S_RESULT;
      end
      S_PUT: begin
        state_d = S_RESULT;
      end
      S_DUMP: begin
        if (res_ready_i && dump_last) begin
          state_d = S_IDLE;
        end
      end
      S_RESULT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    op_d        = op_q;
    val_d       = val_q;
    pos_d       = pos_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    wa_d        = wa_q;
    slot_d      = slot_q;
    st_d        = st_q;
    ins_d       = ins_q;
    pend_d      = pend_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '{status: st_q, item_value: '0, last: 1'b1};
    res_index_o = '0;
    mem_ctl_o   = '{we: 1'b0, re: 1'b0};
    mem_waddr_o = wa_q;
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = ptr_q;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        op_d       = func_i;
        val_d      = value_i;
        pos_d      = position_i;
      end
      S_DECIDE: begin
        st_d   = dec_st;
        ins_d  = is_ins;
        slot_d = AddrW'(slot_c);
        pend_d = 1'b0;
        if (dec_st == ST_OK) begin
          if (is_ins && need_shift) begin
            ptr_d = AddrW'(count_q - CntW'(1));
          end else if (is_del) begin
            if (need_shift) begin
              ptr_d = AddrW'(slot_c + CntW'(1));
            end else begin
              count_d = count_q - CntW'(1);
            end
          end else if (is_dump) begin
            mem_ctl_o.re = 1'b1;
            mem_raddr_o  = '0;
            ptr_d        = '0;
          end
        end
      end
      S_SHIFT: begin
        // Read one slot while writing the entry read in the cycle before into its neighbour.
        mem_ctl_o.re = 1'b1;
        mem_ctl_o.we = pend_q;
        pend_d       = 1'b1;
        wa_d         = ptr_back;
        if (!shift_done) begin
          ptr_d = ptr_step;
        end
      end
      S_DRAIN: begin
        mem_ctl_o.we = 1'b1;
        if (!ins_q) begin
          count_d = count_q - CntW'(1);
        end
      end
      S_PUT: begin
        mem_ctl_o.we = 1'b1;
        mem_waddr_o  = slot_q;
        mem_wdata_o  = val_q;
        count_d      = count_q + CntW'(1);
      end
      S_DUMP: begin
        res_valid_o = 1'b1;
        res_o       = '{status: ST_OK, item_value: mem_rdata_i, last: dump_last};
        res_index_o = dump_idx;
        mem_raddr_o = ptr_q + AddrW'(1);
        if (res_ready_i && !dump_last) begin
          mem_ctl_o.re = 1'b1;
          ptr_d        = ptr_q + AddrW'(1);
        end
      end
      S_RESULT: begin
        res_valid_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign count_o = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    val_q  <= val_d;
    pos_q  <= pos_d;
    ptr_q  <= ptr_d;
    wa_q   <= wa_d;
    slot_q <= slot_d;
    st_q   <= st_d;
    ins_q  <= ins_d;
  end

endmodule

// ----- rtl/positional_sequence_store_top.sv -----
// Top level of the positional sequence store: sequencer, entry memory and
// the output register that decouples results from the downstream side.
// Depends on pss_pkg, pss_mem and pss_ctrl.
//
// The block holds an ordered sequence of up to DEPTH signed 32-bit values in a
// single-port-write, single-port-read memory, slot 0 being the front. One
// request is taken at a time: in_ready_o is high only while the sequencer is
// idle. A request goes through a decode state, then, for an insert or delete
// that moves entries, a shift state (the memory reads one slot and writes the
// slot read in the cycle before into its neighbour) and a drain state and, for
// an insert, a put state that writes the new value; a delete at the back or
// an insert at the back needs no move. The single result of a non-dump
// request is then offered from the result state. A dump streams one result
// per cycle for each held entry while the results are taken; an empty dump
// gives one result with status empty. Rejected requests (bad position, full,
// empty) change nothing and report their status in a single result. Every
// result carries the count held after the request, and last marks the final
// result of a request. Results pass through an output register, so the
// sequencer keeps working while a finished result waits to be taken. After
// reset the store is empty; the memory itself needs no clearing because no
// slot at or above the count is ever read.
module positional_sequence_store_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [2:0]                  func_i,
  input  logic signed [31:0]          value_i,
  input  logic [7:0]                  position_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic signed [31:0]          item_value_o,
  output logic [$clog2(DEPTH+1)-1:0]  item_index_o,
  output logic [$clog2(DEPTH+1)-1:0]  count_o,
  output logic                        last_o
);
  import pss_pkg::*;

  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);

  logic             res_valid, res_ready;
  res_t             res;
  logic [CntW-1:0]  res_index, cur_count;
  mem_ctl_t         mem_ctl;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [ValW-1:0]  mem_wdata, mem_rdata;

  // Output register state.
  logic             out_valid_q, out_valid_d;
  logic [1:0]       status_q;
  logic [ValW-1:0]  item_value_q;
  logic [CntW-1:0]  item_index_q, count_q;
  logic             last_q;

  pss_ctrl #(
    .Depth (DEPTH),
    .AddrW (AddrW),
    .CntW  (CntW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .value_i     (value_i),
    .position_i  (position_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .res_index_o (res_index),
    .count_o     (cur_count),
    .mem_ctl_o   (mem_ctl),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  pss_mem #(
    .Depth (DEPTH),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // The register takes a new result whenever it is empty or being drained.
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_ready) begin
      out_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      status_q     <= res.status;
      item_value_q <= res.item_value;
      item_index_q <= res_index;
      count_q      <= cur_count;
      last_q       <= res.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign item_value_o = item_value_q;
  assign item_index_o = item_index_q;
  assign count_o      = count_q;
  assign last_o       = last_q;

  // The held count can never exceed the store's depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (count_o <= CntW'(DEPTH)))
    else $error("result count exceeds depth");

  // Only a dump yields results that are not last, and those are always ok.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> (status_o == ST_OK))
    else $error("non-final result with error status");

  // A dumped entry index lies within the count held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (item_index_o != '0)) |-> (item_index_o <= count_o))
    else $error("dump index beyond count");

  // The sequencer takes no second request in the cycle after one is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while busy");

endmodule
